// ===== rtl/wsdf_pkg.sv =====
// wsdf_pkg: shared types and constants of the websocket deframer/unmasker
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package wsdf_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [3:0]  opcode_type;
   typedef logic [15:0] length_type;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_NOT_MASKED = 3'd1,
      STATUS_NOT_FINAL  = 3'd2,
      STATUS_RSV_SET    = 3'd3,
      STATUS_LEN64      = 3'd4
   } status_type;

   // 7-bit length codes
   localparam logic [6:0] LEN_CODE_16BIT = 7'd126;
   localparam int unsigned KEY_BYTES     = 4;

endpackage

`default_nettype wire

// ===== rtl/wsdf_req_if.sv =====
// wsdf_req_if: valid/ready channel carrying one received frame byte
// depends on wsdf_pkg
`default_nettype none

interface wsdf_req_if import wsdf_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type byte_value;
   logic     frame_start;

   modport source (output valid, output byte_value, output frame_start, input ready);
   modport sink   (input valid, input byte_value, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/wsdf_rsp_if.sv =====
// wsdf_rsp_if: valid/ready channel carrying one header or payload record
// depends on wsdf_pkg
`default_nettype none

interface wsdf_rsp_if import wsdf_pkg::*; ();
   logic       valid;
   logic       ready;
   kind_type   record_kind;
   byte_type   data_byte;
   opcode_type frame_opcode;
   length_type payload_length;
   status_type status;
   logic       last;

   modport source (output valid, output record_kind, output data_byte, output frame_opcode,
                   output payload_length, output status, output last, input ready);
   modport sink   (input valid, input record_kind, input data_byte, input frame_opcode,
                   input payload_length, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/websocket_frame_deframer_unmask_unit.sv =====
// websocket_frame_deframer_unmask_unit: parses received websocket frames byte by byte
// and unmasks the payload; depends on wsdf_pkg, wsdf_req_if, wsdf_rsp_if
//
// usage:
//   req_chan takes one frame byte per transaction; frame_start marks the first byte of
//   a frame and always restarts the parser, abandoning any frame in progress.
//   rsp_chan gives at most one record per input byte: an accepted header after the
//   fourth key byte, a rejection on the second header byte, or one unmasked payload
//   byte per payload transaction (last set on the final byte).
//   bytes before a frame start or after a rejection give no record.
// throughput and timing:
//   one byte per cycle unless a held record stalls req_chan; a record is visible
//   in the next cycle; parser state and output register update in the same cycle.
// reset:
//   synchronous active-high reset returns the parser to waiting for a frame start and
//   empties the output register.
// stall:
//   the output register holds its record while rsp_chan.ready is low; req_chan.ready
//   stays high as long as the output register is empty or being drained this cycle.
`default_nettype none

module websocket_frame_deframer_unmask_unit import wsdf_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   wsdf_req_if.sink   req_chan,
   wsdf_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SECOND,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_KEY,
      PH_DATA
   } phase_type;

   phase_type  phase_ff, phase_in;
   opcode_type opcode_ff, opcode_in;
   length_type length_ff, length_in;
   length_type index_ff, index_in;
   logic       fin_ff, fin_in;
   logic [2:0] rsv_ff, rsv_in;
   byte_type   key_ff [KEY_BYTES];

   logic       out_valid_ff;
   kind_type   kind_ff, kind_in;
   byte_type   data_ff, data_in;
   opcode_type out_opcode_ff, out_opcode_in;
   length_type out_length_ff, out_length_in;
   status_type status_ff, status_in;
   logic       last_ff, last_in;
   logic       emit;

   logic       accept;
   logic       key_write;
   logic [16:0] index_next;
   logic       data_last;
   status_type fault;

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign index_next = {1'b0, index_ff} + 17'd1;
   assign data_last  = index_next >= {1'b0, length_ff};

   // first fault in priority order
   always_comb begin
      fault = STATUS_OK;
      if (!req_chan.byte_value[7]) begin
         fault = STATUS_NOT_MASKED;
      end else if (!fin_ff) begin
         fault = STATUS_NOT_FINAL;
      end else if (rsv_ff != 3'd0) begin
         fault = STATUS_RSV_SET;
      end else if (req_chan.byte_value[6:0] > LEN_CODE_16BIT) begin
         fault = STATUS_LEN64;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      opcode_in     = opcode_ff;
      length_in     = length_ff;
      index_in      = index_ff;
      fin_in        = fin_ff;
      rsv_in        = rsv_ff;
      key_write     = 1'b0;
      emit          = 1'b0;
      kind_in       = KIND_DATA;
      data_in       = '0;
      out_opcode_in = opcode_ff;
      out_length_in = '0;
      status_in     = STATUS_OK;
      last_in       = 1'b0;

      if (req_chan.frame_start) begin
         fin_in    = req_chan.byte_value[7];
         rsv_in    = req_chan.byte_value[6:4];
         opcode_in = req_chan.byte_value[3:0];
         length_in = '0;
         index_in  = '0;
         phase_in  = PH_SECOND;
      end else begin
         unique case (phase_ff)
            PH_SECOND: begin
               if (fault != STATUS_OK) begin
                  emit      = 1'b1;
                  kind_in   = KIND_REJECT;
                  status_in = fault;
                  last_in   = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  index_in = '0;
                  if (req_chan.byte_value[6:0] == LEN_CODE_16BIT) begin
                     phase_in = PH_LEN_HI;
                  end else begin
                     length_in = {9'd0, req_chan.byte_value[6:0]};
                     phase_in  = PH_KEY;
                  end
               end
            end
            PH_LEN_HI: begin
               length_in = {req_chan.byte_value, 8'd0};
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = {length_ff[15:8], req_chan.byte_value};
               index_in  = '0;
               phase_in  = PH_KEY;
            end
            PH_KEY: begin
               key_write = 1'b1;
               index_in  = index_next[15:0];
               if (index_ff[1:0] == 2'd3) begin
                  // key complete: header record
                  emit          = 1'b1;
                  kind_in       = KIND_ACCEPT;
                  out_length_in = length_ff;
                  last_in       = (length_ff == '0);
                  index_in      = '0;
                  phase_in      = (length_ff == '0) ? PH_IDLE : PH_DATA;
               end
            end
            PH_DATA: begin
               emit          = 1'b1;
               kind_in       = KIND_DATA;
               data_in       = req_chan.byte_value ^ key_ff[index_ff[1:0]];
               out_length_in = length_ff;
               last_in       = data_last;
               index_in      = index_next[15:0];
               if (data_last) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         opcode_ff    <= '0;
         length_ff    <= '0;
         index_ff     <= '0;
         fin_ff       <= 1'b0;
         rsv_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            opcode_ff <= opcode_in;
            length_ff <= length_in;
            index_ff  <= index_in;
            fin_ff    <= fin_in;
            rsv_ff    <= rsv_in;
         end
         if (accept) begin
            out_valid_ff <= emit;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         // record fields carry no reset, qualified by out_valid_ff
         if (accept && emit) begin
            kind_ff       <= kind_in;
            data_ff       <= data_in;
            out_opcode_ff <= out_opcode_in;
            out_length_ff <= out_length_in;
            status_ff     <= status_in;
            last_ff       <= last_in;
         end
      end
   end

   // key store, no reset
   always_ff @(posedge clock) begin
      if (accept && key_write) begin
         key_ff[index_ff[1:0]] <= req_chan.byte_value;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.record_kind    = kind_ff;
   assign rsp_chan.data_byte      = data_ff;
   assign rsp_chan.frame_opcode   = out_opcode_ff;
   assign rsp_chan.payload_length = out_length_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.last           = last_ff;

   // key phase only ever counts the four key bytes
   a_key_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_KEY |-> index_ff[15:2] == 14'd0)
      else $error("key index out of range");

   // payload index never reaches the frame length
   a_data_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> index_ff < length_ff)
      else $error("payload index beyond frame length");

   // a rejection always ends the frame with a fault code
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && kind_ff == KIND_REJECT |-> last_ff && status_ff != STATUS_OK)
      else $error("rejection without last or status");

   // accepted header is last exactly for an empty frame
   a_header_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && kind_ff == KIND_ACCEPT |-> last_ff == (out_length_ff == '0))
      else $error("header last flag mismatch");

   // last payload byte returns the parser to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      accept && !req_chan.frame_start && phase_ff == PH_DATA && data_last
      |=> phase_ff == PH_IDLE)
      else $error("parser not idle after last payload byte");

endmodule

`default_nettype wire

// ===== sim/tb_websocket_frame_deframer_unmask_unit.sv =====
// testbench for websocket_frame_deframer_unmask_unit: directed and random frame bytes with
// an in-bench frame parser that predicts every header, rejection and unmasked payload record
// depends on wsdf_pkg, wsdf_req_if, wsdf_rsp_if and the deframer rtl
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_unmask_unit;
   import wsdf_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned END_SLACK    = 20;
   localparam int unsigned MAX_PRINTED  = 100;

   typedef enum logic [2:0] {
      PARSE_IDLE, PARSE_SECOND, PARSE_LEN_HI, PARSE_LEN_LO, PARSE_KEY, PARSE_DATA
   } parse_state_type;

   typedef enum int {
      MODE_NONE, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH, MODE_HOLD
   } idle_mode_type;

   typedef struct packed {
      kind_type   kind;
      byte_type   data;
      opcode_type opcode;
      length_type length;
      status_type status;
      logic       last;
   } record_type;

   typedef struct {
      byte_type value;
      logic     start;
   } frame_byte_type;

   logic clock = 1'b0;
   logic reset;

   wsdf_req_if req_chan ();
   wsdf_rsp_if rsp_chan ();

   websocket_frame_deframer_unmask_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // parser state mirrored from the byte stream
   parse_state_type parse_state = PARSE_IDLE;
   logic [3:0]      fin_rsv     = '0;
   opcode_type      cur_opcode  = '0;
   length_type      cur_length  = '0;
   length_type      key_index   = '0;
   byte_type        mask_key [4];

   frame_byte_type pending_bytes [$];
   record_type     expected_records [$];

   idle_mode_type idle_mode      = MODE_NONE;
   int unsigned   hold_count     = 0;
   int unsigned   queued_count   = 0;
   int unsigned   counted_items  = 0;
   int unsigned   accepted_count = 0;
   int unsigned   cycle_count    = 0;
   int unsigned   error_count    = 0;
   int unsigned   payload_count  = 0;
   int unsigned   accept_count   = 0;
   int unsigned   reject_count   = 0;
   int unsigned   input_stalls   = 0;
   logic          req_taken      = 1'b0;

   // returns 1 when the byte produces a record
   function automatic bit parse_frame_byte(input byte_type b, input logic start,
                                           output record_type rec);
      status_type st;
      bit         is_last;
      rec = '{KIND_DATA, 8'h00, 4'h0, 16'h0000, STATUS_OK, 1'b0};
      parse_frame_byte = 1'b0;
      if (start) begin
         fin_rsv     = b[7:4];
         cur_opcode  = b[3:0];
         cur_length  = '0;
         key_index   = '0;
         parse_state = PARSE_SECOND;
      end else begin
         case (parse_state)
            PARSE_SECOND: begin
               st = STATUS_OK;
               if (!b[7])                      st = STATUS_NOT_MASKED;
               else if (!fin_rsv[3])           st = STATUS_NOT_FINAL;
               else if (fin_rsv[2:0] != 3'b0)  st = STATUS_RSV_SET;
               else if (b[6:0] > LEN_CODE_16BIT) st = STATUS_LEN64;
               if (st != STATUS_OK) begin
                  rec.kind    = KIND_REJECT;
                  rec.opcode  = cur_opcode;
                  rec.status  = st;
                  rec.last    = 1'b1;
                  parse_state = PARSE_IDLE;
                  parse_frame_byte = 1'b1;
               end else begin
                  key_index = '0;
                  if (b[6:0] == LEN_CODE_16BIT) begin
                     parse_state = PARSE_LEN_HI;
                  end else begin
                     cur_length  = {9'd0, b[6:0]};
                     parse_state = PARSE_KEY;
                  end
               end
            end
            PARSE_LEN_HI: begin
               cur_length  = {b, 8'h00};
               parse_state = PARSE_LEN_LO;
            end
            PARSE_LEN_LO: begin
               cur_length[7:0] = b;
               key_index       = '0;
               parse_state     = PARSE_KEY;
            end
            PARSE_KEY: begin
               mask_key[key_index[1:0]] = b;
               key_index = key_index + 16'd1;
               if (key_index >= 16'(KEY_BYTES)) begin
                  rec.kind    = KIND_ACCEPT;
                  rec.opcode  = cur_opcode;
                  rec.length  = cur_length;
                  rec.last    = (cur_length == 16'd0);
                  key_index   = '0;
                  parse_state = (cur_length == 16'd0) ? PARSE_IDLE : PARSE_DATA;
                  parse_frame_byte = 1'b1;
               end
            end
            PARSE_DATA: begin
               is_last     = ({1'b0, key_index} + 17'd1 >= {1'b0, cur_length});
               rec.kind    = KIND_DATA;
               rec.data    = b ^ mask_key[key_index[1:0]];
               rec.opcode  = cur_opcode;
               rec.length  = cur_length;
               rec.last    = is_last;
               key_index   = key_index + 16'd1;
               if (is_last) parse_state = PARSE_IDLE;
               parse_frame_byte = 1'b1;
            end
            default: parse_state = PARSE_IDLE;
         endcase
      end
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic queue_byte(input byte_type value, input logic start, input bit counted);
      frame_byte_type item;
      item.value = value;
      item.start = start;
      pending_bytes.push_back(item);
      queued_count++;
      if (counted) counted_items++;
   endtask

   // well-formed masked frame; keep < 0 sends it whole, otherwise only the first keep bytes
   task automatic queue_good_frame(input int unsigned length, input bit wide, input int keep);
      byte_type   frame_q [$];
      length_type len16;
      int         n;
      len16 = 16'(length);
      frame_q.push_back({4'b1000, 4'($urandom_range(15))});
      if (wide) begin
         frame_q.push_back({1'b1, LEN_CODE_16BIT});
         frame_q.push_back(len16[15:8]);
         frame_q.push_back(len16[7:0]);
      end else begin
         frame_q.push_back({1'b1, 7'(length)});
      end
      repeat (KEY_BYTES) frame_q.push_back(8'($urandom_range(255)));
      repeat (length) frame_q.push_back(8'($urandom_range(255)));
      n = (keep < 0 || keep > frame_q.size()) ? frame_q.size() : keep;
      for (int i = 0; i < n; i++) queue_byte(frame_q[i], i == 0, 1'b1);
   endtask

   task automatic queue_random_frame();
      int unsigned pick;
      int unsigned length;
      bit          wide;
      int          keep;
      pick = $urandom_range(99);
      if (pick < 6) begin
         // noise outside any frame
         repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (pick < 18) begin
         // arbitrary header bytes, mostly rejected
         queue_byte(8'($urandom_range(255)), 1'b1, 1'b1);
         queue_byte(8'($urandom_range(255)), 1'b0, 1'b1);
         repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end else begin
         pick = $urandom_range(99);
         wide = 1'b0;
         if (pick < 64)      length = $urandom_range(0, 8);
         else if (pick < 84) length = $urandom_range(9, 40);
         else if (pick < 86) length = 125;
         else if (pick < 97) begin
            wide   = 1'b1;
            length = $urandom_range(0, 20);
         end else begin
            wide   = 1'b1;
            length = $urandom_range(126, 300);
         end
         keep = ($urandom_range(99) < 8) ? int'($urandom_range(1, length + 8)) : -1;
         queue_good_frame(length, wide, keep);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (accepted_count != queued_count || expected_records.size() != 0);
      @(posedge clock);
   endtask

   task automatic run_random_phase(input idle_mode_type mode, input int unsigned items);
      int unsigned goal;
      goal = counted_items + items;
      // a long payload up front so the hold-off backs up into the input
      if (mode == MODE_HOLD) queue_good_frame(60, 1'b0, -1);
      while (counted_items < goal) queue_random_frame();
      idle_mode = mode;
      wait_drained();
   endtask

   // byte driver
   always @(negedge clock) begin : byte_driver
      frame_byte_type item;
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.byte_value  <= '0;
         req_chan.frame_start <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_bytes.size() != 0
             && !(idle_mode == MODE_SEND_IDLE && $urandom_range(99) < 87)
             && !(idle_mode == MODE_BOTH && $urandom_range(99) < 15)) begin
            item = pending_bytes.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.byte_value  <= item.value;
            req_chan.frame_start <= item.start;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (idle_mode == MODE_HOLD && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
   end

   always @(negedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else if (idle_mode == MODE_HOLD && hold_count < HOLD_CYCLES)
         rsp_chan.ready <= 1'b0;
      else if (idle_mode == MODE_RECV_STALL)
         rsp_chan.ready <= ($urandom_range(99) >= 87);
      else if (idle_mode == MODE_BOTH)
         rsp_chan.ready <= ($urandom_range(99) >= 15);
      else
         rsp_chan.ready <= 1'b1;
   end

   // monitor: predict on input transactions, check on output transactions
   always @(posedge clock) begin : record_monitor
      record_type predicted;
      record_type got;
      record_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end else begin
         cycle_count++;
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && !req_chan.ready) input_stalls++;
         if (req_chan.valid && req_chan.ready) begin
            accepted_count++;
            if (parse_frame_byte(req_chan.byte_value, req_chan.frame_start, predicted))
               expected_records.push_back(predicted);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.record_kind, rsp_chan.data_byte, rsp_chan.frame_opcode,
                    rsp_chan.payload_length, rsp_chan.status, rsp_chan.last};
            case (got.kind)
               KIND_DATA:   payload_count++;
               KIND_ACCEPT: accept_count++;
               default:     reject_count++;
            endcase
            if (expected_records.size() == 0) begin
               report_mismatch($sformatf("unexpected record kind %0d", got.kind));
            end else begin
               want = expected_records.pop_front();
               if (got.kind !== want.kind)
                  report_mismatch($sformatf("record_kind %0d, expected %0d",
                                            got.kind, want.kind));
               if (got.data !== want.data)
                  report_mismatch($sformatf("data_byte %h, expected %h", got.data, want.data));
               if (got.opcode !== want.opcode)
                  report_mismatch($sformatf("frame_opcode %h, expected %h",
                                            got.opcode, want.opcode));
               if (got.length !== want.length)
                  report_mismatch($sformatf("payload_length %0d, expected %0d",
                                            got.length, want.length));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
            end
         end
      end
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.byte_value  = '0;
      req_chan.frame_start = 1'b0;
      rsp_chan.ready       = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stray byte before any frame start
      queue_byte(8'h3C, 1'b0, 1'b0);
      // 16-bit length of 65535, abandoned by a start right after its header
      queue_byte(8'h8A, 1'b1, 1'b1);
      queue_byte({1'b1, LEN_CODE_16BIT}, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(8'h5A, 1'b0, 1'b1);
      queue_byte(8'hA5, 1'b0, 1'b1);
      // empty frame: header carries last
      queue_byte(8'h81, 1'b1, 1'b1);
      queue_byte(8'h80, 1'b0, 1'b1);
      queue_byte(8'h12, 1'b0, 1'b1);
      queue_byte(8'h34, 1'b0, 1'b1);
      queue_byte(8'h56, 1'b0, 1'b1);
      queue_byte(8'h78, 1'b0, 1'b1);
      // one payload byte under an all-ones key
      queue_byte(8'h82, 1'b1, 1'b1);
      queue_byte(8'h81, 1'b0, 1'b1);
      repeat (KEY_BYTES) queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b1);
      // not masked, then a byte that must be ignored
      queue_byte(8'h81, 1'b1, 1'b1);
      queue_byte(8'h05, 1'b0, 1'b1);
      queue_byte(8'h77, 1'b0, 1'b0);
      // not final together with reserved bits: not final wins
      queue_byte(8'h31, 1'b1, 1'b1);
      queue_byte(8'h80, 1'b0, 1'b1);
      // reserved bit set
      queue_byte(8'hC1, 1'b1, 1'b1);
      queue_byte(8'h80, 1'b0, 1'b1);
      // 64-bit length code
      queue_byte(8'h8F, 1'b1, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);
      wait_drained();

      run_random_phase(MODE_NONE, 380);
      run_random_phase(MODE_SEND_IDLE, 380);
      run_random_phase(MODE_RECV_STALL, 380);
      run_random_phase(MODE_BOTH, 380);
      run_random_phase(MODE_HOLD, 130);
      idle_mode = MODE_NONE;
      repeat (END_SLACK) @(posedge clock);

      if (expected_records.size() != 0)
         report_mismatch($sformatf("%0d expected records never arrived",
                                   expected_records.size()));
      $display("sent %0d frame bytes over five idling modes, input held off %0d cycles",
               accepted_count, input_stalls);
      $display("checked %0d payload bytes, %0d accepted headers, %0d rejections, %0d errors",
               payload_count, accept_count, reject_count, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
